FILE: sv/kprf_pkg.sv
package kprf_pkg;

   // Queue and request sizing.
   localparam int QUEUE_DEPTH   = 16;
   localparam int REQUEST_SPACE = 16;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int RLEN_W        = $clog2(REQUEST_SPACE);
   localparam int MIN_REQ_LEN   = 5;
   localparam int FIELD_COUNT   = 3;

   // Lockout timer.
   localparam int          TICK_W        = 24;
   localparam logic [23:0] LOCKOUT_RESET = 24'd5000000;

   // Key codes.
   localparam logic [7:0] KEY_NONE = 8'h00;
   localparam logic [7:0] KEY_HASH = 8'h23;
   localparam logic [7:0] KEY_STAR = 8'h2A;

   // Word kinds on the request side.
   typedef enum logic [1:0] {
      KIND_KEY  = 2'd0,
      KIND_TICK = 2'd1,
      KIND_POP  = 2'd2,
      KIND_IDLE = 2'd3
   } kind_type;

   // Framing status reported with each response word.
   typedef enum logic [1:0] {
      STAT_NONE    = 2'd0,
      STAT_QUEUED  = 2'd1,
      STAT_INVALID = 2'd2,
      STAT_DROPPED = 2'd3
   } status_type;

   // Response word, last field in the lowest bits.
   typedef struct packed {
      logic [5:0]  pad;
      logic [4:0]  queue_count;
      logic        entry_ready;
      logic [7:0]  head_courier;
      logic [7:0]  head_station_units;
      logic [7:0]  head_station_tens;
      logic        message_ready;
      status_type  request_status;
      logic [7:0]  accepted_key;
      logic        key_accepted;
   } rsp_word_type;

   // Key code of each matrix position, index row*4+column.
   function automatic logic [7:0] key_code(input logic [3:0] pos);
      logic [7:0] code;
      begin
         case (pos)
            4'd0:    code = 8'd1;
            4'd1:    code = 8'd2;
            4'd2:    code = 8'd3;
            4'd3:    code = 8'h41;
            4'd4:    code = 8'd4;
            4'd5:    code = 8'd5;
            4'd6:    code = 8'd6;
            4'd7:    code = 8'h42;
            4'd8:    code = 8'd7;
            4'd9:    code = 8'd8;
            4'd10:   code = 8'd9;
            4'd11:   code = 8'h43;
            4'd12:   code = KEY_STAR;
            4'd13:   code = KEY_NONE;
            4'd14:   code = KEY_HASH;
            default: code = 8'h44;
         endcase
         return code;
      end
   endfunction

   // The lowest set bit wins: lowest row first, then lowest column.
   function automatic logic [7:0] decode_matrix(input logic [15:0] matrix);
      logic [3:0] pos;
      begin
         pos = 4'd0;
         for (int i = 15; i >= 0; i--) begin
            if (matrix[i]) begin
               pos = 4'(i);
            end
         end
         return (matrix == 16'd0) ? KEY_NONE : key_code(pos);
      end
   endfunction

endpackage

FILE: sv/keypad_request_framer_unit.sv
// Channel    Dir  Handshake               Contents
// req        in   req_tvalid/req_tready   tuser: kind; tdata: key_matrix
// rsp        out  rsp_tvalid/rsp_tready   tdata: the nine status fields, see port
// csr        in   csr_write_enable        csr_write_data: lockout_ticks
//
// Each request word is decoded and folded into the state in the cycle it is
// accepted; the output register presents its response word in the next cycle.
// Unstalled, one word per cycle: the register refills in the cycle it drains.
// Reset is synchronous; the message store and key fields are not reset.
// A stalled response holds req_tready low until the word is taken.
module keypad_request_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [15:0] req_tdata,   // key_matrix
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // key_accepted, accepted_key, request_status, message_ready,
   // head_station_tens, head_station_units, head_courier, entry_ready,
   // queue_count, zero pad
   output logic [47:0] rsp_tdata,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);
   import kprf_pkg::*;

   logic                      req_fire;
   kind_type                  kind;
   logic [23:0]               lockout_ticks_ff;
   logic                      ready_ff, ready_in;
   logic [TICK_W-1:0]         count_ff, count_in, count_inc;
   logic [7:0]                prev_key_ff, prev_key_in;
   logic [RLEN_W-1:0]         req_len_ff, req_len_in;
   logic [7:0]                field_ff [FIELD_COUNT];
   logic [23:0]               msg_store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0]         stored_ff, stored_in;
   logic [7:0]                key;
   logic                      accept_key;
   logic                      field_we;
   logic [1:0]                field_idx;
   logic                      push;
   logic [23:0]               new_msg, head_msg;
   status_type                status;
   rsp_word_type              rsp_in, rsp_ff;
   logic                      rsp_valid_ff;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign kind       = kind_type'(req_tuser);
   assign key        = decode_matrix(req_tdata);
   assign count_inc  = count_ff + 1'b1;
   assign new_msg    = {field_ff[0], field_ff[1], field_ff[2]};

   // Next state for one request word.
   always_comb begin
      ready_in    = ready_ff;
      count_in    = count_ff;
      prev_key_in = prev_key_ff;
      req_len_in  = req_len_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      stored_in   = stored_ff;
      accept_key  = 1'b0;
      field_we    = 1'b0;
      field_idx   = 2'd0;
      push        = 1'b0;
      status      = STAT_NONE;
      case (kind)
         KIND_KEY: begin
            if (ready_ff && key != KEY_NONE && key != prev_key_ff) begin
               accept_key  = 1'b1;
               prev_key_in = key;
               ready_in    = 1'b0;
               count_in    = '0;
               if (req_len_ff != '0 || key == KEY_HASH) begin
                  // Store the key while the request still has room.
                  if (req_len_ff < RLEN_W'(REQUEST_SPACE - 1)) begin
                     req_len_in = req_len_ff + 1'b1;
                     if (req_len_ff >= RLEN_W'(1) && req_len_ff <= RLEN_W'(3)) begin
                        field_we  = 1'b1;
                        field_idx = 2'(req_len_ff - 1'b1);
                     end
                  end
                  // A star closes the request.
                  if (key == KEY_STAR) begin
                     req_len_in = '0;
                     if (req_len_ff < RLEN_W'(REQUEST_SPACE - 1) &&
                         req_len_ff >= RLEN_W'(MIN_REQ_LEN - 1)) begin
                        prev_key_in = KEY_NONE;
                        if (stored_ff >= QCNT_W'(QUEUE_DEPTH)) begin
                           status = STAT_DROPPED;
                        end else begin
                           push      = 1'b1;
                           status    = STAT_QUEUED;
                           stored_in = stored_ff + 1'b1;
                           wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                       '0 : wr_ptr_ff + 1'b1;
                        end
                     end else begin
                        status = STAT_INVALID;
                     end
                  end
               end
            end
         end
         KIND_TICK: begin
            if (count_inc >= lockout_ticks_ff || count_inc == '0) begin
               count_in = '0;
               ready_in = 1'b1;
            end else begin
               count_in = count_inc;
            end
         end
         KIND_POP: begin
            if (stored_ff != '0) begin
               stored_in = stored_ff - 1'b1;
               rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ?
                           '0 : rd_ptr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Head of the queue after this word, with the new message forwarded.
   always_comb begin
      if (stored_in == '0) begin
         head_msg = '0;
      end else if (push && wr_ptr_ff == rd_ptr_in) begin
         head_msg = new_msg;
      end else begin
         head_msg = msg_store_ff[rd_ptr_in];
      end
   end

   // Response word.
   always_comb begin
      rsp_in                    = '0;
      rsp_in.key_accepted       = accept_key;
      rsp_in.accepted_key       = accept_key ? key : KEY_NONE;
      rsp_in.request_status     = status;
      rsp_in.message_ready      = (stored_in != '0);
      rsp_in.head_station_tens  = head_msg[23:16];
      rsp_in.head_station_units = head_msg[15:8];
      rsp_in.head_courier       = head_msg[7:0];
      rsp_in.entry_ready        = ready_in;
      rsp_in.queue_count        = 5'(stored_in);
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_RESET;
         ready_ff         <= 1'b0;
         count_ff         <= '0;
         prev_key_ff      <= KEY_NONE;
         req_len_ff       <= '0;
         rd_ptr_ff        <= '0;
         wr_ptr_ff        <= '0;
         stored_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            lockout_ticks_ff <= csr_write_data;
         end
         if (req_fire) begin
            ready_ff    <= ready_in;
            count_ff    <= count_in;
            prev_key_ff <= prev_key_in;
            req_len_ff  <= req_len_in;
            rd_ptr_ff   <= rd_ptr_in;
            wr_ptr_ff   <= wr_ptr_in;
            stored_ff   <= stored_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload storage: key fields, message store and response register.
   always_ff @(posedge clock) begin
      if (req_fire && field_we) begin
         field_ff[field_idx] <= key;
      end
      if (req_fire && push) begin
         msg_store_ff[wr_ptr_ff] <= new_msg;
      end
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // The queue never holds more messages than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      stored_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("message queue count above depth");

   // Taking a key always restarts the lockout.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.key_accepted) |-> !rsp_ff.entry_ready)
      else $error("key accepted while entry still ready");

   // The ready flag agrees with the reported count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.message_ready == (rsp_ff.queue_count != 5'd0)))
      else $error("message_ready disagrees with queue_count");

   // Every accepted request word yields a response word next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("response word missing after accepted request");

endmodule

FILE: tb/tb_keypad_request_framer_unit.sv
module tb_keypad_request_framer_unit;
   import kprf_pkg::*;

   // Letter keys of the matrix.
   localparam logic [7:0] KEY_A = 8'h41;
   localparam logic [7:0] KEY_B = 8'h42;
   localparam logic [7:0] KEY_C = 8'h43;
   localparam logic [7:0] KEY_D = 8'h44;

   // Key code of each matrix bit at bit index times eight, lowest bit listed last.
   localparam logic [127:0] KEY_ROM = {
      KEY_D,  KEY_HASH, KEY_NONE, KEY_STAR,
      KEY_C,  8'd9,     8'd8,     8'd7,
      KEY_B,  8'd6,     8'd5,     8'd4,
      KEY_A,  8'd3,     8'd2,     8'd1
   };

   localparam int STALL_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = KIND_IDLE;   // kind
   logic [15:0] req_tdata = '0;          // key_matrix
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // key_accepted, accepted_key, request_status, message_ready,
   // head_station_tens, head_station_units, head_courier, entry_ready,
   // queue_count, zero pad
   logic [47:0] rsp_tdata;
   logic        csr_write_enable = 1'b0;
   logic [23:0] csr_write_data = '0;

   keypad_request_framer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted framer state.
   logic [23:0] lock_limit;
   logic        entry_open;
   logic [23:0] tick_count;
   logic [7:0]  held_key;
   int          req_len;
   logic [7:0]  fields [FIELD_COUNT];
   logic [23:0] msg_fifo [QUEUE_DEPTH];
   int          rd_ptr;
   int          wr_ptr;
   int          msg_count;

   rsp_word_type status_words_due [$];
   int words_sent    = 0;
   int mismatches    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int idle_cycles   = 0;

   // The lowest set bit wins, which is the lowest row and then the lowest column.
   function automatic logic [7:0] scan_matrix(input logic [15:0] m);
      logic [7:0] code;
      logic       found;
      code = KEY_NONE;
      found = 1'b0;
      for (int b = 0; b < 16; b++) begin
         if (!found && m[b]) begin
            code = KEY_ROM[b*8 +: 8];
            found = 1'b1;
         end
      end
      return code;
   endfunction

   // Folds one request word into the predicted state and returns its response word.
   function automatic rsp_word_type advance_framer(input kind_type kind,
                                                   input logic [15:0] matrix);
      rsp_word_type w;
      logic [7:0]   key;
      logic [23:0]  nxt;
      logic [23:0]  head;
      logic         stored;
      w = '0;
      key = scan_matrix(matrix);
      nxt = tick_count + 24'd1;
      stored = 1'b0;
      case (kind)
         KIND_KEY: begin
            if (entry_open && key != KEY_NONE && key != held_key) begin
               w.key_accepted = 1'b1;
               w.accepted_key = key;
               held_key = key;
               entry_open = 1'b0;
               tick_count = '0;
               // Keys outside an open request are only counted against the lockout.
               if (req_len != 0 || key == KEY_HASH) begin
                  if (req_len < REQUEST_SPACE - 1) begin
                     if (req_len >= 1 && req_len <= FIELD_COUNT) begin
                        fields[req_len-1] = key;
                     end
                     req_len++;
                     stored = 1'b1;
                  end
                  if (key == KEY_STAR) begin
                     if (stored && req_len >= MIN_REQ_LEN) begin
                        if (msg_count >= QUEUE_DEPTH) begin
                           w.request_status = STAT_DROPPED;
                        end else begin
                           msg_fifo[wr_ptr] = {fields[0], fields[1], fields[2]};
                           wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
                           msg_count++;
                           w.request_status = STAT_QUEUED;
                        end
                        held_key = KEY_NONE;
                     end else begin
                        w.request_status = STAT_INVALID;
                     end
                     req_len = 0;
                  end
               end
            end
         end
         KIND_TICK: begin
            if (nxt >= lock_limit || nxt == 24'd0) begin
               tick_count = '0;
               entry_open = 1'b1;
            end else begin
               tick_count = nxt;
            end
         end
         KIND_POP: begin
            if (msg_count > 0) begin
               rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
               msg_count--;
            end
         end
         default: begin
         end
      endcase
      head = (msg_count > 0) ? msg_fifo[rd_ptr] : 24'd0;
      w.message_ready      = (msg_count > 0);
      w.head_station_tens  = head[23:16];
      w.head_station_units = head[15:8];
      w.head_courier       = head[7:0];
      w.entry_ready        = entry_open;
      w.queue_count        = 5'(msg_count);
      return w;
   endfunction

   // Matrix that selects one key, with stray bits above it half of the time.
   function automatic logic [15:0] matrix_for(input logic [7:0] code);
      logic [15:0] m;
      logic [15:0] above;
      m = '0;
      for (int b = 15; b >= 0; b--) begin
         if (b != 13 && KEY_ROM[b*8 +: 8] == code) begin
            m = 16'd1 << b;
         end
      end
      above = ~((m << 1) - 16'd1);
      if ($urandom_range(1) == 1) begin
         m = m | (16'($urandom) & above);
      end
      return m;
   endfunction

   // A request body key: mostly digits and letters, now and then a hash or a repeat.
   function automatic logic [7:0] body_key();
      int         p;
      logic [7:0] code;
      code = 8'd1;
      for (int tries = 0; tries < 20; tries++) begin
         p = $urandom_range(15);
         code = KEY_ROM[p*8 +: 8];
         if (p == 12 || p == 13) continue;
         if (p == 14 && $urandom_range(7) != 0) continue;
         if (code == held_key && $urandom_range(9) != 0) continue;
         break;
      end
      if (code == KEY_NONE || code == KEY_STAR) begin
         code = 8'd5;
      end
      return code;
   endfunction

   // Sends one request word and records its expected response when it is taken.
   task automatic send_word(input kind_type kind, input logic [15:0] matrix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= matrix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      status_words_due.push_back(advance_framer(kind, matrix));
   endtask

   // Ticks until the lockout has elapsed, then presses the key.
   task automatic press_key(input logic [7:0] code);
      while (!entry_open) send_word(KIND_TICK, 16'($urandom));
      send_word(KIND_KEY, matrix_for(code));
   endtask

   // A hash, a body of keys and optionally the closing star.
   task automatic send_request(input int body_len, input bit closed);
      press_key(KEY_HASH);
      for (int i = 0; i < body_len; i++) press_key(body_key());
      if (closed) press_key(KEY_STAR);
   endtask

   // Holds the sender off until every expected response word has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (status_words_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_lockout(input logic [23:0] ticks);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      lock_limit = ticks;
   endtask

   // With the reset lockout no tick count reached here unlocks entry.
   task automatic test_locked_after_reset();
      send_word(KIND_KEY, 16'hFFFF);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_TICK, 16'hFFFF);
      send_word(KIND_KEY, 16'h0001);
      send_word(KIND_POP, 16'h5A5A);
      send_word(KIND_IDLE, 16'hA5A5);
   endtask

   // Single keys, the dead zero key, repeats and the shortest framing cases.
   task automatic test_single_keys();
      press_key(KEY_A);
      press_key(KEY_A);
      send_word(KIND_KEY, 16'h0008);
      send_word(KIND_TICK, 16'h0000);
      send_word(KIND_KEY, 16'h0000);
      send_word(KIND_KEY, 16'h2000);
      send_word(KIND_KEY, 16'hE000);
      send_word(KIND_KEY, 16'h8000);
      send_word(KIND_TICK, 16'hFFFF);
      send_word(KIND_KEY, 16'hFFFF);
      // A five key request queues its middle keys; a four key one is thrown away.
      press_key(KEY_HASH);
      press_key(8'd1);
      press_key(8'd2);
      press_key(8'd3);
      press_key(KEY_STAR);
      press_key(KEY_HASH);
      press_key(8'd4);
      press_key(8'd5);
      press_key(KEY_STAR);
      send_word(KIND_POP, 16'h0000);
      send_word(KIND_POP, 16'hFFFF);
      send_word(KIND_IDLE, 16'hFFFF);
   endtask

   // Keys past the request space are taken but not stored, so the request fails.
   task automatic test_request_overflow();
      press_key(KEY_HASH);
      for (int i = 0; i < 16; i++) press_key((i % 2 == 0) ? KEY_B : KEY_C);
      press_key(KEY_STAR);
      send_request(REQUEST_SPACE - 3, 1'b1);
      send_request(REQUEST_SPACE - 2, 1'b1);
      send_request(3, 1'b1);
      send_word(KIND_POP, 16'h0000);
   endtask

   // Sends one request more than the queue has entries so that it fills and drops, then pops past empty.
   task automatic test_queue_full();
      for (int i = 0; i <= QUEUE_DEPTH; i++) send_request(3, 1'b1);
      for (int i = 0; i <= QUEUE_DEPTH; i++) send_word(KIND_POP, 16'($urandom));
   endtask

   // The longest lockout never elapses here; a zero lockout acts as one tick.
   task automatic test_lockout_extremes();
      write_lockout(24'hFFFFFF);
      for (int i = 0; i < 12; i++) begin
         send_word(($urandom_range(1) == 0) ? KIND_TICK : KIND_KEY, 16'($urandom));
      end
      write_lockout(24'd0);
      send_word(KIND_TICK, 16'h0000);
      send_request(4, 1'b1);
      send_word(KIND_POP, 16'h0000);
   endtask

   // Mostly well-formed requests with random content, mixed with pops and noise.
   task automatic test_random_traffic();
      int  goal;
      int  pop_share;
      int  pick;
      bit  paused;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_lockout(24'd1); pop_share = 20; end
            1: begin write_lockout(24'($urandom_range(2, 5))); pop_share = 3; end
            2: begin write_lockout(24'd3); pop_share = 20; end
            3: begin write_lockout(24'd1); pop_share = 3; end
            4: begin write_lockout(24'($urandom_range(1, 4))); pop_share = 20; end
            default: begin write_lockout(24'd2); pop_share = 12; end
         endcase
         if (phase < 2) begin
            send_idle_pct = 7;
            rsp_stall_pct = 59;
         end else if (phase < 4) begin
            send_idle_pct = 59;
            rsp_stall_pct = 7;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         goal = words_sent + 70;
         paused = 1'b0;
         while (words_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               pick = $urandom_range(99);
               if (pick < 70) send_request($urandom_range(3, 6), 1'b1);
               else if (pick < 85) send_request($urandom_range(0, 2), 1'b1);
               else if (pick < 95) send_request($urandom_range(13, 16), 1'b1);
               else send_request($urandom_range(1, 5), 1'b0);
            end else if (pick < 60 + pop_share) begin
               send_word(KIND_POP, 16'($urandom));
            end else begin
               send_word(kind_type'($urandom_range(3)), 16'($urandom));
            end
            if (!paused && words_sent > goal - 35) begin
               settle();
               paused = 1'b1;
            end
         end
      end
   endtask

   // Receiver stalls at random in the proportion of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // Every response word taken is compared with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (status_words_due.size() == 0) begin
            mismatches++;
            $error("response word %0h arrived with none expected", rsp_tdata);
         end else begin
            want = status_words_due.pop_front();
            check_field("key_accepted", want.key_accepted, got.key_accepted);
            check_field("accepted_key", want.accepted_key, got.accepted_key);
            check_field("request_status", want.request_status, got.request_status);
            check_field("message_ready", want.message_ready, got.message_ready);
            check_field("head_station_tens", want.head_station_tens,
                        got.head_station_tens);
            check_field("head_station_units", want.head_station_units,
                        got.head_station_units);
            check_field("head_courier", want.head_courier, got.head_courier);
            check_field("entry_ready", want.entry_ready, got.entry_ready);
            check_field("queue_count", want.queue_count, got.queue_count);
            check_field("pad", want.pad, got.pad);
         end
      end
   end

   // Ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      lock_limit = LOCKOUT_RESET;
      entry_open = 1'b0;
      tick_count = '0;
      held_key   = KEY_NONE;
      req_len    = 0;
      rd_ptr     = 0;
      wr_ptr     = 0;
      msg_count  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 7;
      rsp_stall_pct = 59;
      test_locked_after_reset();
      write_lockout(24'd1);
      test_single_keys();
      test_request_overflow();
      test_queue_full();
      test_lockout_extremes();
      test_random_traffic();
      settle();
      if (mismatches == 0 && status_words_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
